@@ hw/rtl/spq_pkg.sv @@
// Shared constants, types and helpers for the stable priority task queue.
`default_nettype none

package spq_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ID_W    = 16;
    localparam int DUR_W   = 16;
    localparam int PRI_W   = 2;
    localparam int ENTRY_W = ID_W + DUR_W + PRI_W;

    // Opcodes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One stored task
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
        logic [PRI_W-1:0] pri;
    } t_entry;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_CMP,
        S_DEQ
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture new task, start walk at the tail
        logic res_full;   // report full
        logic res_empty;  // report empty
        logic rd_head;    // read the head entry
        logic rd_prev;    // read the entry below the walk position
        logic shift;      // move the read entry up one place, step down
        logic put_new;    // write the new task at the walk position
        logic pop;        // return the head entry and drop it
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic k_zero;
        logic pri_gt;
    } t_sts;

    // Map a logical position to a physical RAM address of the ring
    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (IDX_W + 1)'(DEPTH)) begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/spq_ctrl.sv @@
// Controller state machine of the stable priority task queue.
`default_nettype none

module spq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_opcode,
    input  wire spq_pkg::t_sts i_sts,
    output spq_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;
    logic            take;

    assign take = start && (r_state == spq_pkg::S_IDLE);

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (take) begin
                    if (i_opcode == spq_pkg::OP_ENQ) begin
                        if (!i_sts.full) n_state = spq_pkg::S_INS;
                    end else begin
                        if (!i_sts.empty) n_state = spq_pkg::S_DEQ;
                    end
                end
            end
            spq_pkg::S_INS: begin
                n_state = i_sts.k_zero ? spq_pkg::S_IDLE : spq_pkg::S_CMP;
            end
            spq_pkg::S_CMP: begin
                n_state = i_sts.pri_gt ? spq_pkg::S_INS : spq_pkg::S_IDLE;
            end
            spq_pkg::S_DEQ: begin
                n_state = spq_pkg::S_IDLE;
            end
            default: n_state = spq_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != spq_pkg::S_IDLE);
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (take) begin
                    if (i_opcode == spq_pkg::OP_ENQ) begin
                        o_cmd.res_full = i_sts.full;
                        o_cmd.load     = !i_sts.full;
                    end else begin
                        o_cmd.res_empty = i_sts.empty;
                        o_cmd.rd_head   = !i_sts.empty;
                    end
                end
            end
            spq_pkg::S_INS: begin
                o_cmd.put_new = i_sts.k_zero;
                o_cmd.rd_prev = !i_sts.k_zero;
            end
            spq_pkg::S_CMP: begin
                o_cmd.shift   = i_sts.pri_gt;
                o_cmd.put_new = !i_sts.pri_gt;
            end
            spq_pkg::S_DEQ: begin
                o_cmd.pop = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTH
    // A shift step always comes straight after a read of the entry below
    a_shift_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.shift |-> $past(o_cmd.rd_prev))
        else $error("shift without preceding read");

    // A pop always follows a head read
    a_pop_after_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> $past(o_cmd.rd_head))
        else $error("pop without head read");

    // At most one result per cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.res_full, o_cmd.res_empty, o_cmd.put_new, o_cmd.pop}))
        else $error("more than one result in a cycle");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/spq_dp.sv @@
// Datapath of the stable priority task queue: ring pointers, walk position, RAM, result.
`default_nettype none

module spq_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire spq_pkg::t_cmd               i_cmd,
    input  wire logic [spq_pkg::ID_W-1:0]    i_task_id,
    input  wire logic [spq_pkg::DUR_W-1:0]   i_task_duration,
    input  wire logic [spq_pkg::PRI_W-1:0]   i_task_priority,
    output spq_pkg::t_sts                    o_sts,
    output logic                             o_strobe,
    output logic [1:0]                       o_status,
    output logic [spq_pkg::ID_W-1:0]         o_out_id,
    output logic [spq_pkg::DUR_W-1:0]        o_out_duration,
    output logic [spq_pkg::PRI_W-1:0]        o_out_priority
);

    logic [spq_pkg::IDX_W-1:0] r_head;
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] r_k;
    spq_pkg::t_entry           r_new;

    logic                      r_strobe;
    logic [1:0]                r_status;
    spq_pkg::t_entry           r_res;

    logic [spq_pkg::CNT_W-1:0] k_dec;
    logic [spq_pkg::IDX_W-1:0] rd_pos;
    logic [spq_pkg::IDX_W-1:0] rd_addr;
    logic [spq_pkg::IDX_W-1:0] wr_addr;
    logic                      rd_en;
    logic                      wr_en;
    spq_pkg::t_entry           wr_data;
    spq_pkg::t_entry           rd_data;
    logic [spq_pkg::ENTRY_W-1:0] rd_word;

    assign k_dec   = r_k - spq_pkg::CNT_W'(1);
    assign rd_pos  = i_cmd.rd_head ? '0 : k_dec[spq_pkg::IDX_W-1:0];
    assign rd_addr = spq_pkg::ring_addr(r_head, rd_pos);
    assign rd_en   = i_cmd.rd_head || i_cmd.rd_prev;
    assign wr_addr = spq_pkg::ring_addr(r_head, r_k[spq_pkg::IDX_W-1:0]);
    assign wr_en   = i_cmd.shift || i_cmd.put_new;
    assign wr_data = i_cmd.shift ? rd_data : r_new;
    assign rd_data = spq_pkg::t_entry'(rd_word);

    // Task storage as a ring
    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (spq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_word)
    );

    // Status to the controller
    assign o_sts.full   = (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign o_sts.empty  = (r_count == '0);
    assign o_sts.k_zero = (r_k == '0);
    assign o_sts.pri_gt = (rd_data.pri > r_new.pri);

    // Advance ring pointers, fill count and walk position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_k     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_k <= r_count;
            end else if (i_cmd.shift) begin
                r_k <= k_dec;
            end
            if (i_cmd.put_new) begin
                r_count <= r_count + spq_pkg::CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - spq_pkg::CNT_W'(1);
                r_head  <= spq_pkg::ring_addr(r_head, spq_pkg::IDX_W'(1));
            end
        end
    end

    // Capture the task to insert
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new.id  <= i_task_id;
            r_new.dur <= i_task_duration;
            r_new.pri <= i_task_priority;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.res_full || i_cmd.res_empty || i_cmd.put_new || i_cmd.pop;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_status <= spq_pkg::ST_OK;
            r_res    <= rd_data;
        end else if (i_cmd.res_full) begin
            r_status <= spq_pkg::ST_FULL;
            r_res    <= '0;
        end else if (i_cmd.res_empty) begin
            r_status <= spq_pkg::ST_EMPTY;
            r_res    <= '0;
        end else if (i_cmd.put_new) begin
            r_status <= spq_pkg::ST_OK;
            r_res    <= '0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_id       = r_res.id;
    assign o_out_duration = r_res.dur;
    assign o_out_priority = r_res.pri;

`ifndef SYNTH
    // Fill count never exceeds the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("fill count above capacity");

    // An insertion grows the queue by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_new |=> r_count == $past(r_count) + spq_pkg::CNT_W'(1))
        else $error("insertion did not grow the queue");

    // A pop only ever comes from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_count != '0)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/stable_priority_task_queue_unit.sv @@
// Top level of the stable priority task queue: controller plus datapath.
`default_nettype none

// Holds up to spq_pkg::DEPTH tasks in a ring RAM, most urgent first and in
// arrival order within a priority. A transaction is taken when start is high
// and busy is low. Its single result is shown for one cycle with o_strobe and
// cannot be held off, so the receiver must take it then. A dequeue reads the
// head at acceptance, then pops it in S_DEQ with busy high; its result is
// registered from the pop and strobes after S_DEQ. An enqueue walks down from
// the tail, moving each less urgent entry up one place. Busy stays high
// through the walk, which ends when it reaches the head or stops at an entry
// of equal or more urgent priority. The result strobes in the cycle busy
// falls. Full and empty reports come the cycle after acceptance, with busy
// staying low. Each moved entry takes an S_INS read and an S_CMP write because
// the RAM has one read port with registered read data. A new transaction may
// start in the same cycle as the previous result strobe.
module stable_priority_task_queue_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_opcode,
    input  wire logic [spq_pkg::ID_W-1:0]    i_task_id,
    input  wire logic [spq_pkg::DUR_W-1:0]   i_task_duration,
    input  wire logic [spq_pkg::PRI_W-1:0]   i_task_priority,
    output logic                             o_strobe,
    output logic [1:0]                       o_status,
    output logic [spq_pkg::ID_W-1:0]         o_out_id,
    output logic [spq_pkg::DUR_W-1:0]        o_out_duration,
    output logic [spq_pkg::PRI_W-1:0]        o_out_priority
);

    spq_pkg::t_cmd cmd;
    spq_pkg::t_sts sts;

    // Sequence each transaction
    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Storage, pointers and result registers
    spq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_task_id       (i_task_id),
        .i_task_duration (i_task_duration),
        .i_task_priority (i_task_priority),
        .o_sts           (sts),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_out_id        (o_out_id),
        .o_out_duration  (o_out_duration),
        .o_out_priority  (o_out_priority)
    );

endmodule

`default_nettype wire

@@ test/spq_checker.sv @@
// Checker for the stable priority task queue: predicts each result and compares it.
module spq_checker
    import spq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_busy,
    input  wire logic             i_opcode,
    input  wire logic [ID_W-1:0]  i_task_id,
    input  wire logic [DUR_W-1:0] i_task_duration,
    input  wire logic [PRI_W-1:0] i_task_priority,
    input  wire logic             i_strobe,
    input  wire logic [1:0]       i_status,
    input  wire logic [ID_W-1:0]  i_out_id,
    input  wire logic [DUR_W-1:0] i_out_duration,
    input  wire logic [PRI_W-1:0] i_out_priority,
    output int                    o_mismatches,
    output int                    o_pending
);

    // One result transaction as the block shows it
    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
        logic [PRI_W-1:0] pri;
    } t_outcome;

    // Shadow copy of the stored tasks, slot 0 being the head
    t_entry   shadow_slot [DEPTH];
    int       shadow_count;
    t_outcome awaited_results [$];
    int       mismatch_count;

    // Print one line per mismatch and count it
    task automatic flag_mismatch(input string what);
        $display("spq_checker: %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Apply one command to the shadow queue and return the result it should give
    function automatic t_outcome apply_to_shadow(input logic op, input t_entry item);
        t_outcome res;
        int       pos;
        res = '0;
        if (op == OP_ENQ) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // insert behind every task of equal or more urgent priority
                pos = 0;
                while (pos < shadow_count && shadow_slot[pos].pri <= item.pri) begin
                    pos++;
                end
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_slot[k] = shadow_slot[k-1];
                end
                shadow_slot[pos] = item;
                shadow_count++;
                res.status = ST_OK;
            end
        end else if (shadow_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            // hand out the head and close the gap
            res.status = ST_OK;
            res.id     = shadow_slot[0].id;
            res.dur    = shadow_slot[0].dur;
            res.pri    = shadow_slot[0].pri;
            for (int k = 1; k < shadow_count; k++) begin
                shadow_slot[k-1] = shadow_slot[k];
            end
            shadow_count--;
        end
        return res;
    endfunction

    // Compare strobed results first, then predict any transaction taken this edge
    always @(posedge i_clk) begin
        t_outcome want;
        t_entry   item;
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            // check the result shown this cycle against the oldest prediction
            if (i_strobe) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("result with no transaction pending: status %0d",
                                            i_status));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status !== want.status) begin
                        flag_mismatch($sformatf("status: want %0d got %0d",
                                                want.status, i_status));
                    end
                    if (i_out_id !== want.id) begin
                        flag_mismatch($sformatf("out_id: want %h got %h",
                                                want.id, i_out_id));
                    end
                    if (i_out_duration !== want.dur) begin
                        flag_mismatch($sformatf("out_duration: want %h got %h",
                                                want.dur, i_out_duration));
                    end
                    if (i_out_priority !== want.pri) begin
                        flag_mismatch($sformatf("out_priority: want %0d got %0d",
                                                want.pri, i_out_priority));
                    end
                end
            end
            // predict the transaction accepted at this edge
            if (i_start && !i_busy) begin
                item.id  = i_task_id;
                item.dur = i_task_duration;
                item.pri = i_task_priority;
                awaited_results.push_back(apply_to_shadow(i_opcode, item));
            end
        end
        o_pending    <= awaited_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ test/tb.sv @@
// Testbench top for the stable priority task queue: stimulus, clock, reset and verdict.
module tb;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_TAIL    = 120;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             start           = 1'b0;
    logic             i_opcode        = OP_ENQ;
    logic [ID_W-1:0]  i_task_id       = '0;
    logic [DUR_W-1:0] i_task_duration = '0;
    logic [PRI_W-1:0] i_task_priority = '0;
    logic             busy;
    logic             o_strobe;
    logic [1:0]       o_status;
    logic [ID_W-1:0]  o_out_id;
    logic [DUR_W-1:0] o_out_duration;
    logic [PRI_W-1:0] o_out_priority;
    int               mismatches;
    int               pending;
    bit               gaps_allowed;

    stable_priority_task_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_task_id       (i_task_id),
        .i_task_duration (i_task_duration),
        .i_task_priority (i_task_priority),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_out_id        (o_out_id),
        .o_out_duration  (o_out_duration),
        .o_out_priority  (o_out_priority)
    );

    spq_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_task_id       (i_task_id),
        .i_task_duration (i_task_duration),
        .i_task_priority (i_task_priority),
        .i_strobe        (o_strobe),
        .i_status        (o_status),
        .i_out_id        (o_out_id),
        .i_out_duration  (o_out_duration),
        .i_out_priority  (o_out_priority),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // Free-running clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #6_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Present one command, hold it until taken, then maybe idle for a burst
    task automatic issue_command(input logic op, input logic [ID_W-1:0] id,
                                 input logic [DUR_W-1:0] dur, input logic [PRI_W-1:0] pri);
        i_opcode        <= op;
        i_task_id       <= id;
        i_task_duration <= dur;
        i_task_priority <= pri;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (gaps_allowed && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    initial begin
        int          lean;
        int          seg_left;
        logic        op;
        logic [1:0]  pri;
        gaps_allowed = 1'b1;
        seg_left     = 0;
        lean         = 50;

        // Hold reset, then release it once
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: dequeue from empty
        issue_command(OP_DEQ, 16'($urandom), 16'($urandom), 2'($urandom));
        // Fill to the brim, cycling priorities 3,2,1,0 with extreme ids and durations
        for (int k = 0; k < DEPTH; k++) begin
            issue_command(OP_ENQ,
                          (k == 0) ? 16'hFFFF : (k == 1) ? 16'h0000 : 16'($urandom),
                          (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom),
                          2'((k * 3 + 3) % 4));
        end
        // Enqueue into a full queue
        issue_command(OP_ENQ, 16'hA5A5, 16'h5A5A, 2'd1);
        // Drain a few; payload fields carry junk that must be ignored
        repeat (4) issue_command(OP_DEQ, 16'($urandom), 16'($urandom), 2'($urandom));

        // Random: segments leaning towards filling, draining or balance
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        lean = 85;
                    end
                    1: begin
                        lean = 15;
                    end
                    default: begin
                        lean = 50;
                    end
                endcase
                seg_left     = $urandom_range(8, 40);
                gaps_allowed = ($urandom_range(0, 2) != 0);
            end
            seg_left--;
            // keep the final stretch free of idling
            if (n >= RANDOM_ITEMS - CALM_TAIL) begin
                gaps_allowed = 1'b0;
            end
            op  = ($urandom_range(0, 99) < lean) ? OP_ENQ : OP_DEQ;
            pri = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            issue_command(op, 16'($urandom), 16'($urandom), pri);
        end
        start <= 1'b0;

        // Drain outstanding results, then allow for the longest walk
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_dp.sv
hw/rtl/stable_priority_task_queue_unit.sv
test/spq_checker.sv
test/tb.sv
